// ===== design/rcec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcec_pkg: shared constants and types for the edge / circle collision block
// Default widths, lane pipeline depth and the per-stage enable bundle.
// ----------------------------------------------------------------------------
package rcec_pkg;

  // default coordinate width (signed, two's complement)
  localparam int COORD_WIDTH_DEF = 32;
  // default number of edges tested (one lane each)
  localparam int EDGE_COUNT_DEF  = 4;
  // corners carried by one item
  localparam int CORNERS         = 4;
  // register stages inside one lane
  localparam int LANE_STAGES     = 5;

  // per-stage load enables handed to the lanes and the merge stage
  typedef struct packed {
    logic [LANE_STAGES:0] en;
  } pipe_ctrl_t;

endpackage

// ===== design/rcec_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcec_lane: one edge against the circle
// Five-stage pipeline: differences, products, quadratic coefficients,
// split partial products of the discriminant, then the hit decision.
// ----------------------------------------------------------------------------
module rcec_lane #(
  parameter int COORD_WIDTH = rcec_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  rcec_pkg::pipe_ctrl_t          ctrl,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic [2*COORD_WIDTH-3:0]      rr,     // radius squared, stage 2 copy
  output logic                          hit
);

  localparam int D  = COORD_WIDTH + 1;   // difference width
  localparam int M  = 2 * D;             // product width
  localparam int P  = 2 * D + 2;         // coefficient width
  localparam int G  = P + 2;             // g(1) width
  localparam int H  = (P + 1) / 2;       // low half of a split coefficient
  localparam int HI = P - H;             // high half
  localparam int HH = 2 * HI;
  localparam int HL = HI + H + 1;
  localparam int LL = 2 * H + 2;
  localparam int Q  = 2 * P + 2;         // discriminant width

  // stage 1: edge vector and offset from the centre
  logic signed [D-1:0] dx_r, dy_r, fx_r, fy_r;
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      dx_r <= $signed({qx[COORD_WIDTH-1], qx}) - $signed({px[COORD_WIDTH-1], px});
      dy_r <= $signed({qy[COORD_WIDTH-1], qy}) - $signed({py[COORD_WIDTH-1], py});
      fx_r <= $signed({px[COORD_WIDTH-1], px}) - $signed({cx[COORD_WIDTH-1], cx});
      fy_r <= $signed({py[COORD_WIDTH-1], py}) - $signed({cy[COORD_WIDTH-1], cy});
    end
  end

  // stage 2: the six products
  logic signed [M-1:0] dxx_r, dyy_r, fdx_r, fdy_r, fxx_r, fyy_r;
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      fdx_r <= fx_r * dx_r;
      fdy_r <= fy_r * dy_r;
      fxx_r <= fx_r * fx_r;
      fyy_r <= fy_r * fy_r;
    end
  end

  // stage 3: a = d.d, b = f.d, c = f.f - r^2
  logic signed [P-1:0] a_r, b_r, c_r;
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      a_r <= P'(dxx_r) + P'(dyy_r);
      b_r <= P'(fdx_r) + P'(fdy_r);
      c_r <= P'(fxx_r) + P'(fyy_r) - P'($signed({1'b0, rr}));
    end
  end

  // stage 4: sign flags and partial products of b*b and a*c
  logic signed [G-1:0]  g1;
  logic signed [P:0]    ab;
  logic signed [HI-1:0] bh, ah, ch;
  logic signed [H:0]    bl, al, cl;
  assign g1 = G'(a_r) + G'(b_r) + G'(b_r) + G'(c_r);
  assign ab = (P+1)'(a_r) + (P+1)'(b_r);
  assign bh = b_r[P-1:H];
  assign ah = a_r[P-1:H];
  assign ch = c_r[P-1:H];
  assign bl = $signed({1'b0, b_r[H-1:0]});
  assign al = $signed({1'b0, a_r[H-1:0]});
  assign cl = $signed({1'b0, c_r[H-1:0]});

  logic c_neg_r, c_pos_r, g_neg_r, g_pos_r, a_pos_r, b_pos_r, ab_neg_r;
  logic signed [HH-1:0] bhh_r, ahh_r;
  logic signed [HL-1:0] bhl_r, ahl_r, alh_r;
  logic signed [LL-1:0] bll_r, all_r;
  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      c_neg_r  <= c_r[P-1];
      c_pos_r  <= !c_r[P-1] && (c_r != '0);
      g_neg_r  <= g1[G-1];
      g_pos_r  <= !g1[G-1] && (g1 != '0);
      a_pos_r  <= !a_r[P-1] && (a_r != '0);
      b_pos_r  <= !b_r[P-1] && (b_r != '0);
      ab_neg_r <= ab[P];
      bhh_r    <= bh * bh;
      bhl_r    <= bh * bl;
      bll_r    <= bl * bl;
      ahh_r    <= ah * ch;
      ahl_r    <= ah * cl;
      alh_r    <= al * ch;
      all_r    <= al * cl;
    end
  end

  // stage 5: discriminant sign and the edge decision
  logic signed [Q-1:0] bb, acp, disc;
  logic                hit_nxt, hit_r;
  assign bb   = (Q'(bhh_r) <<< (2 * H)) + (Q'(bhl_r) <<< (H + 1)) + Q'(bll_r);
  assign acp  = (Q'(ahh_r) <<< (2 * H)) + ((Q'(ahl_r) + Q'(alh_r)) <<< H) + Q'(all_r);
  assign disc = bb - acp;

  always_comb begin
    if (!c_neg_r && !g_pos_r)       hit_nxt = 1'b1;   // ends on opposite sides or touch
    else if (!c_pos_r && !g_neg_r)  hit_nxt = 1'b1;
    else if (c_neg_r || g_neg_r)    hit_nxt = 1'b0;   // both ends strictly inside
    else if (!a_pos_r)              hit_nxt = 1'b0;   // degenerate edge
    else if (b_pos_r || ab_neg_r)   hit_nxt = 1'b0;   // vertex outside the edge
    else                            hit_nxt = !disc[Q-1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// ===== design/rcec_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcec_merge: combine the lane results
// ORs the per-edge hits into the registered result.
// ----------------------------------------------------------------------------
module rcec_merge #(
  parameter int EDGE_COUNT = rcec_pkg::EDGE_COUNT_DEF
) (
  input  logic                  clk,
  input  rcec_pkg::pipe_ctrl_t  ctrl,
  input  logic [EDGE_COUNT-1:0] lane_hit,
  output logic                  hit
);

  logic hit_r;

  // result register, loads with the last stage enable
  always_ff @(posedge clk) begin
    if (ctrl.en[rcec_pkg::LANE_STAGES]) begin
      hit_r <= |lane_hit;
    end
  end

  assign hit = hit_r;

endmodule

// ===== design/rectangle_circle_edge_collision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_circle_edge_collision: quadrilateral edge / circle hit test
// Top level: lanes per edge, merge stage and the pipeline valid chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready carries one item: four corners and a
//   circle (centre, radius). Result channel out_valid / out_ready carries
//   out_hit, set when any closed edge crosses or touches the circle.
//   An item passes through six register stages (five in each lane, one in
//   the merge); out_valid rises when it reaches the last. One item is taken
//   every cycle while the receiver takes results, and each stage then passes
//   an item on every cycle.
//   Each stage holds its item only while the stage after it is full and
//   stalled, so bubbles close up and in_ready stays high while any stage
//   is empty. A stalled receiver fills the pipeline, after which in_ready
//   drops until the result is taken; no item is lost.
//   Reset clears all stage valids; nothing else needs clearing, and the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module rectangle_circle_edge_collision #(
  parameter int COORD_WIDTH = rcec_pkg::COORD_WIDTH_DEF,
  parameter int EDGE_COUNT  = rcec_pkg::EDGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner3_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner3_y,
  input  logic signed [COORD_WIDTH-1:0] in_circle_x,
  input  logic signed [COORD_WIDTH-1:0] in_circle_y,
  input  logic [COORD_WIDTH-2:0]        in_circle_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit
);

  localparam int NS = rcec_pkg::LANE_STAGES + 1;   // total register stages

  // valid chain with bubble collapse
  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0]   rdy;
  rcec_pkg::pipe_ctrl_t ctrl;

  assign rdy[NS] = out_ready;
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = !vld_r[k] || rdy[k+1];
    end
  endgenerate

  assign ctrl.en = rdy[NS-1:0];

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_valid;
    for (int s = 1; s < NS; s++) begin
      if (rdy[s]) vld_nxt[s] = vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];

  // radius squared, shared by all lanes, kept in step with lane stage 2
  logic [2*COORD_WIDTH-3:0] rr1_r, rr2_r;
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) rr1_r <= in_circle_radius * in_circle_radius;
    if (ctrl.en[1]) rr2_r <= rr1_r;
  end

  // corner table for lane wiring
  logic signed [COORD_WIDTH-1:0] cor_x [rcec_pkg::CORNERS];
  logic signed [COORD_WIDTH-1:0] cor_y [rcec_pkg::CORNERS];
  assign cor_x[0] = in_corner0_x;
  assign cor_y[0] = in_corner0_y;
  assign cor_x[1] = in_corner1_x;
  assign cor_y[1] = in_corner1_y;
  assign cor_x[2] = in_corner2_x;
  assign cor_y[2] = in_corner2_y;
  assign cor_x[3] = in_corner3_x;
  assign cor_y[3] = in_corner3_y;

  // one lane per edge
  logic [EDGE_COUNT-1:0] lane_hit;
  genvar i;
  generate
    for (i = 0; i < EDGE_COUNT; i++) begin : g_lane
      localparam int PI = i % rcec_pkg::CORNERS;
      localparam int QI = ((i + 1) % EDGE_COUNT) % rcec_pkg::CORNERS;
      rcec_lane #(
        .COORD_WIDTH (COORD_WIDTH)
      ) u_lane (
        .clk  (clk),
        .ctrl (ctrl),
        .px   (cor_x[PI]),
        .py   (cor_y[PI]),
        .qx   (cor_x[QI]),
        .qy   (cor_y[QI]),
        .cx   (in_circle_x),
        .cy   (in_circle_y),
        .rr   (rr2_r),
        .hit  (lane_hit[i])
      );
    end
  endgenerate

  // merge stage
  rcec_merge #(
    .EDGE_COUNT (EDGE_COUNT)
  ) u_merge (
    .clk      (clk),
    .ctrl     (ctrl),
    .lane_hit (lane_hit),
    .hit      (out_hit)
  );

`ifndef NO_ASSERTIONS
  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item did not enter stage 1");

  // a taking receiver never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // a full, stalled middle stage keeps its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && !rdy[3] |=> vld_r[2])
    else $error("stalled stage dropped its item");
`endif

endmodule
